// ===== sv/coordinate_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Coordinate frame parser assertion macros
// Shared macros for concurrent checks clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_FRAME_PARSER_CORE_ASSERT_SVH
`define COORDINATE_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser package
// Types, codes and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfp_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 9;
    localparam int WORD_W    = 19;
    localparam int COUNT_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd3;

    // Register reset values: '<', '>', '|' and '!'.
    localparam logic [BYTE_W-1:0] START_RST     = 8'd60;
    localparam logic [BYTE_W-1:0] STOP_RST      = 8'd62;
    localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'd124;
    localparam logic [BYTE_W-1:0] DELIMITER_RST = 8'd33;

    // Control word bit positions.
    localparam int CTRL_ENABLE  = 7;
    localparam int CTRL_DISABLE = 6;
    localparam int CTRL_RESET   = 5;

    localparam logic [BYTE_W-1:0]  CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0]  CHAR_9     = 8'h39;
    localparam logic [COUNT_W-1:0] MAX_DIGITS = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MAX  = 9'd511;
    localparam logic [WORD_W-1:0]  RESET_WORD = 19'h40000;

    // Word kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] open_byte;
        logic [BYTE_W-1:0] close_byte;
        logic [BYTE_W-1:0] separator_char;
        logic [BYTE_W-1:0] delimiter_char;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              kind;
    } result_t;

    // Appends one decimal digit and saturates at the coordinate maximum.
    function automatic logic [COORD_W-1:0] add_digit(input logic [COORD_W-1:0] v,
                                                     input logic [3:0] d);
        logic [12:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {9'd0, d};
        if (n > {4'd0, COORD_MAX})
        begin
            return COORD_MAX;
        end
        return n[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/cfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser configuration registers
// Holds the start, stop, separator and delimiter byte values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_cfg_regs
    import cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_START:     cfg_next.open_byte      = cfg_data;
                REG_STOP:      cfg_next.close_byte     = cfg_data;
                REG_SEPARATOR: cfg_next.separator_char = cfg_data;
                REG_DELIMITER: cfg_next.delimiter_char = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{open_byte:      START_RST,
                         close_byte:     STOP_RST,
                         separator_char: SEPARATOR_RST,
                         delimiter_char: DELIMITER_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/cfp_parser.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser state update
// Applies one word to the frame and link state and forms its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_parser
    import cfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              command,
    input  logic [BYTE_W-1:0] byte_value,
    input  cfg_t              cfg,
    output result_t           result
);

    phase_t               phase_reg, phase_next;
    logic [COORD_W-1:0]   x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 link_reg, link_next;
    logic                 pend_reg, pend_next;
    logic                 in_field;
    logic [BYTE_W-1:0]    digit_off;

    assign in_field  = (phase_reg == PH_X) || (phase_reg == PH_Y);
    assign digit_off = byte_value - CHAR_0;

    always_comb
    begin
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        count_next = count_reg;
        link_next  = link_reg;
        pend_next  = pend_reg;
        result     = '0;
        if (fire)
        begin
            if (command)
            begin
                if (byte_value[CTRL_ENABLE])
                begin
                    link_next = 1'b1;
                end
                if (byte_value[CTRL_DISABLE])
                begin
                    link_next = 1'b0;
                end
                if (byte_value[CTRL_RESET])
                begin
                    link_next    = 1'b0;
                    pend_next    = 1'b1;
                    result.valid = 1'b1;
                    result.word  = RESET_WORD;
                    result.kind  = KIND_RESET;
                end
            end
            else if (link_reg)
            begin
                if (byte_value == cfg.open_byte)
                begin
                    phase_next = PH_X;
                    x_next     = '0;
                    y_next     = '0;
                    count_next = '0;
                end
                else if (byte_value == cfg.close_byte)
                begin
                    if (in_field)
                    begin
                        result.valid = 1'b1;
                        result.word  = {pend_reg, y_reg, x_reg};
                        result.kind  = KIND_FRAME;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                end
                else if (byte_value == cfg.separator_char)
                begin
                    if (phase_reg == PH_X)
                    begin
                        phase_next = PH_Y;
                        count_next = '0;
                    end
                end
                else if (byte_value != cfg.delimiter_char && in_field)
                begin
                    if (byte_value inside {[CHAR_0:CHAR_9]})
                    begin
                        if (count_reg < MAX_DIGITS)
                        begin
                            if (phase_reg == PH_X)
                            begin
                                x_next = add_digit(x_reg, digit_off[3:0]);
                            end
                            else
                            begin
                                y_next = add_digit(y_reg, digit_off[3:0]);
                            end
                            count_next = count_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // A stray character freezes the current field.
                        count_next = MAX_DIGITS;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
            link_reg  <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_next;
            link_reg  <= link_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== sv/cfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_out_reg
    import cfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           result,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] rf_word,
    output logic              word_kind
);

    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              kind_reg;

    // The parser only fires when this register is empty or being drained.
    always_comb
    begin
        if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            word_reg <= result.word;
            kind_reg <= result.kind;
        end
    end

    assign out_valid = valid_reg;
    assign rf_word   = word_reg;
    assign word_kind = kind_reg;

endmodule

// ===== sv/coordinate_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser core
// Parses start/X/separator/Y/stop byte frames into packed coordinate words.
// ----------------------------------------------------------------------------
// An accepted word waits in the input stage until the parser fires on it, and
// its result is then registered in the output register and shown on out_valid.
// Throughput: one input word per cycle while the output register has room.
// A word that produces no result still occupies the input stage until it fires.
// Reset (rst_n low, asynchronous): link enabled, parser idle, reset flag clear,
// configuration bytes back to '<', '>', '|' and '!', no output pending.
`timescale 1ns / 1ps

module coordinate_frame_parser_core
    import cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [BYTE_W-1:0]    byte_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    rf_word,
    output logic                 word_kind,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    // Input stage. A word sits here until the parser
    // applies it; the stage refills in the same cycle it drains.
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_cmd_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              in_accept;
    logic              fire;
    cfg_t              cfg;
    result_t           result;

    // The parser may only move when the output register has room, since
    // any word could produce a result.
    assign fire      = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !s1_valid_reg || fire;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= byte_value;
        end
    end

    // Start, stop, separator and delimiter byte values.
    cfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame and link state; one word is applied per fire.
    cfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .command    (s1_cmd_reg),
        .byte_value (s1_byte_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // Result register facing the downstream handshake.
    cfp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rf_word   (rf_word),
        .word_kind (word_kind)
    );

endmodule

// ===== sv/cfp_port_checker.sv =====
// ----------------------------------------------------------------------------
// Coordinate frame parser port checker
// Watches the top-level ports and checks result words over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "coordinate_frame_parser_core_assert.svh"

module cfp_port_checker
    import cfp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] rf_word,
    input logic              word_kind
);

    logic seen_reset_reg;

    // Set once a reset word has been delivered downstream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reset_reg <= 1'b0;
        end
        else if (out_valid && out_ready && word_kind == KIND_RESET)
        begin
            seen_reset_reg <= 1'b1;
        end
    end

    `CFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rf_word) && $stable(word_kind), "stalled result word changed")
    `CFP_ASSERT_NOW(a_reset_word, out_valid && word_kind == KIND_RESET, rf_word == RESET_WORD, "reset word carries coordinate bits")
    `CFP_ASSERT_NOW(a_sticky_flag, out_valid && word_kind == KIND_FRAME && seen_reset_reg, rf_word[WORD_W-1], "frame word after a reset lacks the reset flag")

endmodule

bind coordinate_frame_parser_core cfp_port_checker u_port_checker (.*);
